// ----- src/swtl_pkg.sv -----
// shared types, constants and word canonicalisation for the sorted word table
package swtl_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int WORD_BYTES_DEF  = 16;
    localparam int FUNC_W          = 2;
    localparam int HALF_W          = 64;
    localparam int WORD_W          = 2 * HALF_W;
    localparam int NUM_BYTES       = WORD_W / 8;
    localparam int ENTRIES_W       = 13;
    localparam int NBYTES_W        = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR  = 2'd0,
        FN_ADD    = 2'd1,
        FN_LOOKUP = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_SHORT = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 found;
        t_status              status;
        logic [ENTRIES_W-1:0] entries;
    } t_result;

    // cut at the first zero byte and at nbytes-1 characters, optional lower-casing
    function automatic logic [WORD_W-1:0] canon(input logic [WORD_W-1:0] w,
                                                input logic lower,
                                                input logic [NBYTES_W-1:0] nbytes);
        logic [NUM_BYTES-1:0] nz;
        logic [NUM_BYTES-1:0] m;
        logic [7:0]           b;
        logic [WORD_W-1:0]    r;
        for (int i = 0; i < NUM_BYTES; i++) begin
            nz[i] = (w[WORD_W-1-8*i -: 8] != 8'd0);
        end
        r = '0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            m = (NUM_BYTES'(1) << (i + 1)) - NUM_BYTES'(1);
            b = w[WORD_W-1-8*i -: 8];
            if (lower && b >= 8'h41 && b <= 8'h5a) begin
                b = b | 8'h20;
            end
            if (((nz & m) == m) && (NBYTES_W'(i) < nbytes - NBYTES_W'(1))) begin
                r[WORD_W-1-8*i -: 8] = b;
            end
        end
        return r;
    endfunction

endpackage

// ----- src/swtl_if.sv -----
// valid/ready channel interfaces for item and result beats
interface swtl_in_if;
    logic                        valid;
    logic                        ready;
    logic [swtl_pkg::FUNC_W-1:0] func;
    logic [swtl_pkg::HALF_W-1:0] word_high;
    logic [swtl_pkg::HALF_W-1:0] word_low;

    modport source (output valid, func, word_high, word_low, input ready);
    modport sink   (input valid, func, word_high, word_low, output ready);
endinterface

interface swtl_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [1:0]                     status;
    logic [swtl_pkg::ENTRIES_W-1:0] entries;

    modport source (output valid, found, status, entries, input ready);
    modport sink   (input valid, found, status, entries, output ready);
endinterface

// ----- src/sorted_word_table_lookup_top.sv -----
// sorted word table with binary-search lookup: top level
// Items arrive on i_in (func, word_high, word_low) as valid/ready beats; one
// result beat (found, status, entries) leaves on o_out for every item.
// func clear empties the table, add lower-cases and appends a word (rejected
// when shorter than two letters or when the table is full), lookup runs a
// binary search over the held words. Words are kept in one 128-bit wide ram.
// Clear, add and unused codes pass from S_IDLE straight to S_DONE; a lookup
// alternates S_PROBE and S_CMP until a hit or an empty range, making at most
// ceil(log2(n + 1)) probes over n words: each probe is one registered ram read
// followed by a 128-bit compare, so 4096 words need up to 13 probes.
// i_in.ready is low while an item is being worked on, so a new item is not
// accepted before the last one reaches S_DONE and is handed on. A finished
// result sits in an output register; if the receiver stalls, the block still
// takes and works the next item, then holds that result until the output
// register frees. Reset empties the table and drops any pending result;
// stale ram contents are never read.
module sorted_word_table_lookup_top #(
    parameter int TABLE_DEPTH = swtl_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_BYTES  = swtl_pkg::WORD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    swtl_in_if.sink     i_in,
    swtl_out_if.source  o_out
);

    localparam int AW = $clog2(TABLE_DEPTH);

    swtl_pkg::t_result           w_res;
    logic                        w_res_valid;
    logic                        w_res_ready;
    logic                        w_ram_we;
    logic [AW-1:0]               w_ram_waddr;
    logic [swtl_pkg::WORD_W-1:0] w_ram_wdata;
    logic                        w_ram_re;
    logic [AW-1:0]               w_ram_raddr;
    logic [swtl_pkg::WORD_W-1:0] w_ram_rdata;

    logic                        r_out_valid, n_out_valid;
    swtl_pkg::t_result           r_out;

    swtl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_BYTES  (WORD_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    swtl_ram #(
        .WIDTH (swtl_pkg::WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // output register
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid && w_res_ready) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.found   = r_out.found;
    assign o_out.status  = r_out.status;
    assign o_out.entries = r_out.entries;

    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res_ready |=> r_out_valid && (r_out == $past(w_res)))
        else $error("result beat not captured in output register");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !w_res_valid && !w_ram_re)
        else $error("new item taken while previous one still in flight");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res.found |-> (w_res.status == swtl_pkg::STAT_OK))
        else $error("found result carries an error status");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> i_in.ready && !w_ram_re)
        else $error("ram write outside the idle state");

endmodule

// ----- src/swtl_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module swtl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/swtl_ctrl.sv -----
// item sequencer: clear, append and binary search over the word ram
module swtl_ctrl #(
    parameter int TABLE_DEPTH = swtl_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_BYTES  = swtl_pkg::WORD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    swtl_in_if.sink                        i_in,
    output swtl_pkg::t_result              o_res,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output logic                           o_ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_waddr,
    output logic [swtl_pkg::WORD_W-1:0]    o_ram_wdata,
    output logic                           o_ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_ram_raddr,
    input  logic [swtl_pkg::WORD_W-1:0]    i_ram_rdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    swtl_pkg::t_state            r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_lo, r_hi;
    logic [AW-1:0]               r_mid;
    logic [swtl_pkg::WORD_W-1:0] r_key;
    swtl_pkg::t_result           r_res;

    logic                        w_accept;
    logic                        w_short;
    logic                        w_full;
    logic                        w_add_ok;
    logic [swtl_pkg::WORD_W-1:0] w_word;
    logic [CW-1:0]               w_mid;
    logic                        w_range;
    swtl_pkg::t_status           w_status;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_word   = {i_in.word_high, i_in.word_low};
    assign w_short  = (w_word[swtl_pkg::WORD_W-1 -: 8] == 8'd0) ||
                      (w_word[swtl_pkg::WORD_W-9 -: 8] == 8'd0);
    assign w_full   = (r_count >= CW'(TABLE_DEPTH));
    assign w_add_ok = (i_in.func == swtl_pkg::FN_ADD) && !w_short && !w_full;
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_range  = (r_lo < r_hi);

    always_comb begin
        w_status = swtl_pkg::STAT_OK;
        if (i_in.func == swtl_pkg::FN_ADD) begin
            if (w_short) begin
                w_status = swtl_pkg::STAT_SHORT;
            end else if (w_full) begin
                w_status = swtl_pkg::STAT_FULL;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            case (i_in.func)
                swtl_pkg::FN_CLEAR: n_count = '0;
                swtl_pkg::FN_ADD: begin
                    if (w_add_ok) begin
                        n_count = r_count + CW'(1);
                    end
                end
                default: n_count = r_count;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swtl_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.func == swtl_pkg::FN_LOOKUP) ? swtl_pkg::S_PROBE
                                                                : swtl_pkg::S_DONE;
                end
            end
            swtl_pkg::S_PROBE: n_state = w_range ? swtl_pkg::S_CMP : swtl_pkg::S_DONE;
            swtl_pkg::S_CMP: begin
                n_state = (r_key == i_ram_rdata) ? swtl_pkg::S_DONE : swtl_pkg::S_PROBE;
            end
            swtl_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = swtl_pkg::S_IDLE;
                end
            end
            default: n_state = swtl_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready  = (r_state == swtl_pkg::S_IDLE);
        o_res_valid = (r_state == swtl_pkg::S_DONE);
        o_res       = r_res;
        o_ram_we    = w_accept && w_add_ok;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = swtl_pkg::canon(w_word, 1'b1, swtl_pkg::NBYTES_W'(WORD_BYTES));
        o_ram_re    = (r_state == swtl_pkg::S_PROBE) && w_range;
        o_ram_raddr = w_mid[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swtl_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key         <= swtl_pkg::canon(w_word, 1'b0,
                                             swtl_pkg::NBYTES_W'(WORD_BYTES));
            r_lo          <= '0;
            r_hi          <= r_count;
            r_res.found   <= 1'b0;
            r_res.status  <= w_status;
            r_res.entries <= swtl_pkg::ENTRIES_W'(n_count);
        end
        if (r_state == swtl_pkg::S_PROBE) begin
            r_mid <= w_mid[AW-1:0];
        end
        if (r_state == swtl_pkg::S_CMP) begin
            if (r_key == i_ram_rdata) begin
                r_res.found <= 1'b1;
            end else if (r_key < i_ram_rdata) begin
                r_hi <= CW'(r_mid);
            end else begin
                r_lo <= CW'(r_mid) + CW'(1);
            end
        end
    end

endmodule

// ----- tb/sv/sorted_word_table_lookup_checker.sv -----
// beat monitor, word table predictor and result comparison for the sorted word table
`timescale 1ns / 1ps

module sorted_word_table_lookup_checker #(
    parameter int TABLE_DEPTH = swtl_pkg::TABLE_DEPTH_DEF,
    parameter int WORD_BYTES  = swtl_pkg::WORD_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swtl_in_if         i_in,
    swtl_out_if        i_out,
    output int         o_errors,
    output int         o_pending
);

    import swtl_pkg::*;

    bit [WORD_W-1:0] table_words [TABLE_DEPTH];
    int              table_count = 0;
    t_result         awaited_results[$];
    int              awaited_count = 0;
    int              error_total = 0;
    int              result_beats = 0;

    assign o_errors  = error_total;
    assign o_pending = awaited_count;

    task automatic report_mismatch(input string msg);
        if (error_total < 50) begin
            $display("%0t ns  result beat %0d  %s", $realtime, result_beats, msg);
        end
        error_total++;
    endtask

    // word ends at the first zero byte or after WORD_BYTES-1 characters
    function automatic bit [WORD_W-1:0] trim_word(input bit [WORD_W-1:0] raw,
                                                  input bit fold, output int len);
        bit [WORD_W-1:0] r;
        bit [7:0]        b;
        bit              stop;
        r    = '0;
        stop = 1'b0;
        len  = 0;
        for (int i = 0; i < NUM_BYTES; i++) begin
            b = raw[WORD_W-1-8*i -: 8];
            if (i >= WORD_BYTES - 1 || b == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                if (fold && b >= 8'h41 && b <= 8'h5a) begin
                    b = b + 8'h20;
                end
                r[WORD_W-1-8*i -: 8] = b;
                len++;
            end
        end
        return r;
    endfunction

    function automatic bit table_has(input bit [WORD_W-1:0] key);
        int lo_idx;
        int hi_idx;
        int mid;
        lo_idx = 0;
        hi_idx = table_count;
        while (lo_idx < hi_idx) begin
            mid = lo_idx + (hi_idx - lo_idx) / 2;
            if (key == table_words[mid]) begin
                return 1'b1;
            end
            if (key < table_words[mid]) begin
                hi_idx = mid;
            end else begin
                lo_idx = mid + 1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result answer_item(input logic [FUNC_W-1:0] fn,
                                            input bit [WORD_W-1:0] raw);
        t_result         r;
        bit [WORD_W-1:0] key;
        int              len;
        r.found  = 1'b0;
        r.status = STAT_OK;
        case (fn)
            FN_CLEAR: begin
                table_count = 0;
            end
            FN_ADD: begin
                key = trim_word(raw, 1'b1, len);
                if (len < 2) begin
                    r.status = STAT_SHORT;
                end else if (table_count >= TABLE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    table_words[table_count] = key;
                    table_count++;
                end
            end
            FN_LOOKUP: begin
                key     = trim_word(raw, 1'b0, len);
                r.found = table_has(key);
            end
            default: begin
            end
        endcase
        r.entries = ENTRIES_W'(table_count);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                result_beats++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result beat with no item outstanding");
                end else begin
                    want = awaited_results.pop_front();
                    if (i_out.found !== want.found) begin
                        report_mismatch($sformatf("found: got %0b, want %0b",
                                                  i_out.found, want.found));
                    end
                    if (i_out.status !== want.status) begin
                        report_mismatch($sformatf("status: got %0d, want %0d",
                                                  i_out.status, want.status));
                    end
                    if (i_out.entries !== want.entries) begin
                        report_mismatch($sformatf("entries: got %0d, want %0d",
                                                  i_out.entries, want.entries));
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                awaited_results.push_back(answer_item(i_in.func,
                                                      {i_in.word_high, i_in.word_low}));
            end
            awaited_count = awaited_results.size();
        end
    end

endmodule

// ----- tb/sv/sorted_word_table_lookup_top_tb.sv -----
// stimulus, clock, reset and verdict for the sorted word table testbench
`timescale 1ns / 1ps

module sorted_word_table_lookup_top_tb;

    import swtl_pkg::*;

    localparam int           TBL_DEPTH     = TABLE_DEPTH_DEF;
    localparam int           TBL_WORD      = WORD_BYTES_DEF;
    localparam logic [1:0]   FN_SPARE      = 2'd3;
    localparam int           RANDOM_TARGET = 1600;
    localparam int           CYCLE_LIMIT   = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycle_count = 0;

    int   send_gap_max = 3;
    int   recv_gap_max = 3;
    int   stall_req = 0;
    int   sent_items = 0;

    bit [WORD_W-1:0] held_words[$];

    swtl_in_if  item_ch();
    swtl_out_if result_ch();

    sorted_word_table_lookup_top #(
        .TABLE_DEPTH (TBL_DEPTH),
        .WORD_BYTES  (TBL_WORD)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (item_ch),
        .o_out   (result_ch)
    );

    sorted_word_table_lookup_checker #(
        .TABLE_DEPTH (TBL_DEPTH),
        .WORD_BYTES  (TBL_WORD)
    ) u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (item_ch),
        .i_out     (result_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit [WORD_W-1:0] text_word(input string s);
        bit [WORD_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < NUM_BYTES; i++) begin
            w[WORD_W-1-8*i -: 8] = s[i];
        end
        return w;
    endfunction

    function automatic int word_length(input bit [WORD_W-1:0] w);
        int n;
        n = 0;
        while (n < NUM_BYTES - 1 && w[WORD_W-1-8*n -: 8] != 8'h00) begin
            n++;
        end
        return n;
    endfunction

    // lower-case word; narrow draws from four letters so probes collide often
    function automatic bit [WORD_W-1:0] make_word(input int len, input bit narrow);
        bit [WORD_W-1:0] w;
        bit [7:0]        b;
        w = '0;
        for (int i = 0; i < len; i++) begin
            if (narrow) begin
                b = 8'h61 + 8'($urandom_range(0, 3));
            end else begin
                b = 8'($urandom_range(1, 255));
                if (b >= 8'h41 && b <= 8'h5a) begin
                    b = b + 8'h20;
                end
            end
            w[WORD_W-1-8*i -: 8] = b;
        end
        return w;
    endfunction

    // junk past the terminator, or in the dropped last byte
    function automatic bit [WORD_W-1:0] scatter_tail(input bit [WORD_W-1:0] w);
        bit [WORD_W-1:0] r;
        int              len;
        int              from;
        r    = w;
        len  = word_length(w);
        from = (len < NUM_BYTES - 1) ? len + 1 : NUM_BYTES - 1;
        if ($urandom_range(0, 2) == 0) begin
            for (int i = from; i < NUM_BYTES; i++) begin
                r[WORD_W-1-8*i -: 8] = 8'($urandom);
            end
        end
        return r;
    endfunction

    function automatic bit [WORD_W-1:0] dress_for_add(input bit [WORD_W-1:0] w);
        bit [WORD_W-1:0] r;
        bit [7:0]        b;
        int              len;
        r   = w;
        len = word_length(w);
        for (int i = 0; i < len; i++) begin
            b = r[WORD_W-1-8*i -: 8];
            if (b >= 8'h61 && b <= 8'h7a && $urandom_range(0, 1) == 1) begin
                r[WORD_W-1-8*i -: 8] = b - 8'h20;
            end
        end
        return scatter_tail(r);
    endfunction

    // lookups are case sensitive, so an upper-case letter turns a hit into a miss
    function automatic bit [WORD_W-1:0] dress_for_lookup(input bit [WORD_W-1:0] w);
        bit [WORD_W-1:0] r;
        bit [7:0]        b;
        int              p;
        r = w;
        if ($urandom_range(0, 7) == 0) begin
            p = $urandom_range(0, word_length(w) - 1);
            b = r[WORD_W-1-8*p -: 8];
            if (b >= 8'h61 && b <= 8'h7a) begin
                r[WORD_W-1-8*p -: 8] = b - 8'h20;
            end
        end
        return scatter_tail(r);
    endfunction

    function automatic bit [WORD_W-1:0] nudge_word(input bit [WORD_W-1:0] w);
        bit [WORD_W-1:0] r;
        int              p;
        r = w;
        p = $urandom_range(0, word_length(w) - 1);
        r[WORD_W-1-8*p -: 8] = r[WORD_W-1-8*p -: 8] ^ 8'($urandom_range(1, 255));
        return r;
    endfunction

    function automatic bit [WORD_W-1:0] probe_word();
        int k;
        k = $urandom_range(0, 99);
        if (held_words.size() != 0 && k < 50) begin
            return dress_for_lookup(held_words[$urandom_range(0, held_words.size() - 1)]);
        end
        if (held_words.size() != 0 && k < 75) begin
            return nudge_word(held_words[$urandom_range(0, held_words.size() - 1)]);
        end
        return make_word($urandom_range(0, 15), 1'($urandom_range(0, 1)));
    endfunction

    function automatic bit [WORD_W-1:0] any_bits();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic push_item(input logic [1:0] fn, input bit [WORD_W-1:0] w);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid     = 1'b1;
        item_ch.func      = fn;
        item_ch.word_high = w[WORD_W-1:HALF_W];
        item_ch.word_low  = w[HALF_W-1:0];
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        sent_items++;
    endtask

    task automatic await_quiet();
        item_ch.valid = 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic build_and_probe(input int n_words, input int n_probes);
        bit [WORD_W-1:0] fresh[$];
        bit [WORD_W-1:0] w;
        int              j;
        push_item(FN_CLEAR, any_bits());
        held_words.delete();
        for (int i = 0; i < n_words; i++) begin
            w = make_word($urandom_range(2, 15), $urandom_range(0, 9) < 7);
            j = 0;
            while (j < fresh.size() && fresh[j] < w) begin
                j++;
            end
            fresh.insert(j, w);
        end
        foreach (fresh[i]) begin
            if ($urandom_range(0, 7) == 0) begin
                push_item(FN_ADD, dress_for_add(make_word($urandom_range(0, 1), 1'b0)));
            end
            push_item(FN_ADD, dress_for_add(fresh[i]));
            held_words.push_back(fresh[i]);
        end
        for (int i = 0; i < n_probes; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(FN_SPARE, any_bits());
            end else begin
                push_item(FN_LOOKUP, probe_word());
            end
        end
    endtask

    task automatic stir_noise(input int n_items);
        logic [1:0]      fn;
        bit [WORD_W-1:0] w;
        for (int i = 0; i < n_items; i++) begin
            fn = 2'($urandom_range(0, 3));
            if (fn == FN_CLEAR && $urandom_range(0, 3) != 0) begin
                fn = FN_LOOKUP;
            end
            if ($urandom_range(0, 1) == 0) begin
                w = any_bits();
            end else begin
                w = dress_for_add(make_word($urandom_range(0, 15), 1'($urandom_range(0, 1))));
            end
            if (fn == FN_CLEAR) begin
                held_words.delete();
            end
            push_item(fn, w);
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : result_sink
        int gap;
        int hold;
        result_ch.ready = 1'b0;
        @(negedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(negedge i_clk);
        end
        forever begin
            if (stall_req != 0) begin
                hold            = stall_req;
                stall_req       = 0;
                result_ch.ready = 1'b0;
                while (hold != 0) begin
                    @(negedge i_clk);
                    hold--;
                end
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap != 0) begin
                result_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            result_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) begin
                @(posedge i_clk);
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        bit [WORD_W-1:0] w;
        bit [WORD_W-1:0] sfx;
        int              fill_items;
        int              mark;
        bit              fill_done;
        int              gap_pick[3];
        gap_pick          = '{0, 3, 17};
        fill_items        = 0;
        fill_done         = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.func      = FN_CLEAR;
        item_ch.word_high = '0;
        item_ch.word_low  = '0;
        i_rst_n           = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, short and full-width words, case folding
        push_item(FN_LOOKUP, '0);
        push_item(FN_SPARE, '1);
        push_item(FN_ADD, '0);
        push_item(FN_ADD, text_word("Q"));
        w = text_word("a");
        w[111:0] = {$urandom, $urandom, $urandom, 16'($urandom)};
        push_item(FN_ADD, w);
        push_item(FN_ADD, text_word("Ab"));
        push_item(FN_LOOKUP, text_word("ab"));
        push_item(FN_LOOKUP, text_word("Ab"));
        w = text_word("ab");
        w[103:0] = {$urandom, $urandom, $urandom, 8'($urandom)};
        push_item(FN_LOOKUP, w);
        w = text_word("CCCCCCCCCCCCCCC");
        w[7:0] = 8'h5a;
        push_item(FN_ADD, w);
        w = text_word("ccccccccccccccc");
        w[7:0] = 8'hff;
        push_item(FN_LOOKUP, w);
        push_item(FN_ADD, '1);
        push_item(FN_LOOKUP, '1);
        push_item(FN_LOOKUP, text_word("aa"));
        push_item(FN_LOOKUP, text_word("zz"));
        push_item(FN_ADD, text_word("bb"));
        push_item(FN_LOOKUP, text_word("bb"));
        push_item(FN_LOOKUP, text_word("ab"));
        push_item(FN_CLEAR, '0);
        push_item(FN_LOOKUP, text_word("ab"));
        push_item(FN_SPARE, '0);
        push_item(FN_ADD, text_word("@AZ[az{"));
        push_item(FN_LOOKUP, text_word("@az[az{"));
        held_words.delete();
        held_words.push_back(text_word("@az[az{"));

        // long receiver hold while items keep coming
        send_gap_max = 0;
        stall_req    = 300;
        for (int i = 0; i < 16; i++) begin
            push_item(FN_LOOKUP, probe_word());
        end
        await_quiet();

        while (sent_items - fill_items < RANDOM_TARGET) begin
            send_gap_max = gap_pick[$urandom_range(0, 2)];
            recv_gap_max = gap_pick[$urandom_range(0, 2)];
            if (!fill_done && sent_items > 700) begin
                // whole table, then adds and lookups against a full table
                fill_done    = 1'b1;
                mark         = sent_items;
                send_gap_max = 1;
                recv_gap_max = 1;
                push_item(FN_CLEAR, any_bits());
                held_words.delete();
                for (int i = 0; i < TBL_DEPTH; i++) begin
                    w = '0;
                    w[127:120] = 8'h61 + 8'(i / 676);
                    w[119:112] = 8'h61 + 8'((i / 26) % 26);
                    w[111:104] = 8'h61 + 8'(i % 26);
                    sfx = make_word($urandom_range(0, 12), 1'b1);
                    w[103:0] = sfx[127:24];
                    push_item(FN_ADD, dress_for_add(w));
                    held_words.push_back(w);
                end
                push_item(FN_ADD, text_word("zzz"));
                push_item(FN_ADD, '1);
                push_item(FN_ADD, text_word("q"));
                push_item(FN_ADD, dress_for_add(make_word(1, 1'b0)));
                for (int i = 0; i < 40; i++) begin
                    push_item(FN_LOOKUP, probe_word());
                end
                push_item(FN_CLEAR, any_bits());
                held_words.delete();
                fill_items = sent_items - mark;
            end else if ($urandom_range(0, 3) == 0) begin
                stir_noise($urandom_range(3, 20));
            end else if ($urandom_range(0, 9) == 0) begin
                build_and_probe($urandom_range(40, 200), $urandom_range(10, 40));
            end else begin
                build_and_probe($urandom_range(0, 24), $urandom_range(1, 30));
            end
            if ($urandom_range(0, 4) == 0) begin
                await_quiet();
            end
        end

        await_quiet();
        repeat (40) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
